>>> rtl/core/pnguf_pkg.sv
// ----------------------------------------------------------------------------
// pnguf_pkg
// shared types and constants of the png scanline unfilter core
// ----------------------------------------------------------------------------
package pnguf_pkg;

	localparam int DATA_W         = 8;
	localparam int ROW_BYTES_W    = 14;
	localparam int BPP_W          = 3;
	localparam int CFG_DATA_W     = 14;
	localparam int CFG_INDEX_W    = 1;

	localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RESET = 14'd8192;
	localparam logic [BPP_W-1:0]       BPP_RESET       = 3'd4;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ROW_BYTES       = 1'b0,
		CFG_BYTES_PER_PIXEL = 1'b1
	} pnguf_cfg_idx_t;

	// row filter codes, bad marks an unknown filter type byte
	typedef enum logic [2:0] {
		FLT_NONE  = 3'd0,
		FLT_SUB   = 3'd1,
		FLT_UP    = 3'd2,
		FLT_AVG   = 3'd3,
		FLT_PAETH = 3'd4,
		FLT_BAD   = 3'd5
	} pnguf_filter_t;

	// per-byte control handed from front to back
	typedef struct packed {
		pnguf_filter_t filter;
		logic          first_row;
		logic          last;
		logic          left_ok;
	} pnguf_ctl_t;

endpackage

>>> rtl/core/pnguf_front.sv
// ----------------------------------------------------------------------------
// pnguf_front
// accepts stream bytes, tracks row position and classifies each byte
// ----------------------------------------------------------------------------
module pnguf_front #(
	parameter int MAX_ROW_BYTES   = 8192,
	parameter int MAX_PIXEL_BYTES = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pnguf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pnguf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                 accept,
	input  logic [pnguf_pkg::DATA_W-1:0]         data_byte,
	input  logic                                 image_start,
	output logic                                 push,
	output pnguf_pkg::pnguf_ctl_t                op_ctl,
	output logic [pnguf_pkg::DATA_W-1:0]         op_data,
	output logic [$clog2(MAX_ROW_BYTES)-1:0]     op_col,
	output logic [$clog2(MAX_PIXEL_BYTES)-1:0]   op_idx
);

	localparam int CW = $clog2(MAX_ROW_BYTES);
	localparam int LW = CW + 1;
	localparam int PW = $clog2(MAX_PIXEL_BYTES);

	logic [pnguf_pkg::ROW_BYTES_W-1:0] row_bytes_q;
	logic [pnguf_pkg::BPP_W-1:0]       bpp_q;
	logic [CW-1:0]                     col_q;
	pnguf_pkg::pnguf_filter_t          filter_q;
	logic                              first_row_q;
	logic                              await_q;

	logic [LW-1:0]                     len_eff;
	logic [PW:0]                       bpp_eff;
	logic                              take_filter;
	logic                              last;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= pnguf_pkg::ROW_BYTES_RESET;
			bpp_q       <= pnguf_pkg::BPP_RESET;
		end else if (cfg_we) begin
			unique case (pnguf_pkg::pnguf_cfg_idx_t'(cfg_index))
				pnguf_pkg::CFG_ROW_BYTES:       row_bytes_q <= cfg_data[pnguf_pkg::ROW_BYTES_W-1:0];
				pnguf_pkg::CFG_BYTES_PER_PIXEL: bpp_q       <= cfg_data[pnguf_pkg::BPP_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp register values to the supported range
	always_comb begin
		if (row_bytes_q == '0)
			len_eff = LW'(1);
		else if (32'(row_bytes_q) > MAX_ROW_BYTES)
			len_eff = LW'(MAX_ROW_BYTES);
		else
			len_eff = LW'(row_bytes_q);
		if (bpp_q == '0)
			bpp_eff = (PW+1)'(1);
		else if (32'(bpp_q) > MAX_PIXEL_BYTES)
			bpp_eff = (PW+1)'(MAX_PIXEL_BYTES);
		else
			bpp_eff = (PW+1)'(bpp_q);
	end

	assign take_filter = image_start || await_q;
	assign last        = (LW'(col_q) + LW'(1)) >= len_eff;
	assign push        = accept && !take_filter;

	always_comb begin
		op_ctl.filter    = filter_q;
		op_ctl.first_row = first_row_q || image_start;
		op_ctl.last      = last;
		op_ctl.left_ok   = 32'(col_q) >= 32'(bpp_eff);
		op_data          = data_byte;
		op_col           = col_q;
		op_idx           = PW'(bpp_eff - (PW+1)'(1));
	end

	// row position tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			filter_q    <= pnguf_pkg::FLT_NONE;
			first_row_q <= 1'b1;
			await_q     <= 1'b1;
		end else if (accept) begin
			if (take_filter) begin
				if (data_byte <= 8'd4)
					filter_q <= pnguf_pkg::pnguf_filter_t'(data_byte[2:0]);
				else
					filter_q <= pnguf_pkg::FLT_BAD;
				await_q <= 1'b0;
				col_q   <= '0;
				if (image_start)
					first_row_q <= 1'b1;
			end else if (last) begin
				col_q       <= '0;
				await_q     <= 1'b1;
				first_row_q <= 1'b0;
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

endmodule

>>> rtl/core/pnguf_queue.sv
// ----------------------------------------------------------------------------
// pnguf_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
module pnguf_queue #(
	parameter int WIDTH      = 32,
	parameter int DEPTH_LOG2 = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             empty,
	output logic             full
);

	localparam int DEPTH = 1 << DEPTH_LOG2;

	logic [WIDTH-1:0]      entry_q [DEPTH];
	logic [DEPTH_LOG2-1:0] wr_ptr_q;
	logic [DEPTH_LOG2-1:0] rd_ptr_q;
	logic [DEPTH_LOG2:0]   count_q;

	assign head  = entry_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign full  = (count_q == (DEPTH_LOG2+1)'(DEPTH));

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + DEPTH_LOG2'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + DEPTH_LOG2'(1);
			if (push && !pop)
				count_q <= count_q + (DEPTH_LOG2+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (DEPTH_LOG2+1)'(1);
		end
	end

endmodule

>>> rtl/core/pnguf_back.sv
// ----------------------------------------------------------------------------
// pnguf_back
// line buffer read, predictor and output register
// ----------------------------------------------------------------------------
module pnguf_back #(
	parameter int MAX_ROW_BYTES   = 8192,
	parameter int MAX_PIXEL_BYTES = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	output logic                                 q_pop,
	input  pnguf_pkg::pnguf_ctl_t                hd_ctl,
	input  logic [pnguf_pkg::DATA_W-1:0]         hd_data,
	input  logic [$clog2(MAX_ROW_BYTES)-1:0]     hd_col,
	input  logic [$clog2(MAX_PIXEL_BYTES)-1:0]   hd_idx,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [pnguf_pkg::DATA_W-1:0]         pixel_byte,
	output logic                                 row_end,
	output logic                                 bad_filter
);

	localparam int CW = $clog2(MAX_ROW_BYTES);
	localparam int PW = $clog2(MAX_PIXEL_BYTES);

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
	                                     input logic [7:0] c);
		logic signed [10:0] p;
		logic signed [10:0] pa;
		logic signed [10:0] pb;
		logic signed [10:0] pc;
		p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
		pa = p - $signed({3'b000, a});
		pb = p - $signed({3'b000, b});
		pc = p - $signed({3'b000, c});
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc)
			return a;
		else if (pb <= pc)
			return b;
		else
			return c;
	endfunction

	logic [7:0]            upper_row_q [MAX_ROW_BYTES];
	logic [7:0]            left_hist_q [MAX_PIXEL_BYTES];
	logic [7:0]            upleft_hist_q [MAX_PIXEL_BYTES];

	logic                  v_s1;
	pnguf_pkg::pnguf_ctl_t ctl_s1;
	logic [7:0]            x_s1;
	logic [CW-1:0]         col_s1;
	logic [PW-1:0]         idx_s1;
	logic                  fwd_s1;
	logic [7:0]            rdata_s1;
	logic [7:0]            last_r_q;

	logic                  out_valid_q;
	logic [7:0]            pixel_q;
	logic                  row_end_q;
	logic                  bad_q;

	logic                  adv;
	logic [7:0]            a;
	logic [7:0]            b;
	logic [7:0]            c;
	logic [7:0]            b_raw;
	logic [7:0]            pred;
	logic [7:0]            r;
	logic [8:0]            sum_ab;
	logic                  bad;

	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && !q_empty;

	// line buffer: read on pop, write as the byte leaves s1
	always_ff @(posedge clk) begin
		if (q_pop)
			rdata_s1 <= upper_row_q[hd_col];
		if (adv && v_s1)
			upper_row_q[col_s1] <= r;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_s1 <= hd_ctl;
			x_s1   <= hd_data;
			col_s1 <= hd_col;
			idx_s1 <= hd_idx;
			// previous byte writes the same column at this edge
			fwd_s1 <= v_s1 && (col_s1 == hd_col);
		end
		if (adv && v_s1)
			last_r_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= !q_empty;
	end

	// predictor
	always_comb begin
		b_raw  = fwd_s1 ? last_r_q : rdata_s1;
		b      = ctl_s1.first_row ? 8'd0 : b_raw;
		a      = ctl_s1.left_ok ? left_hist_q[idx_s1] : 8'd0;
		c      = (ctl_s1.left_ok && !ctl_s1.first_row) ? upleft_hist_q[idx_s1] : 8'd0;
		sum_ab = {1'b0, a} + {1'b0, b};
		bad    = (ctl_s1.filter == pnguf_pkg::FLT_BAD) || (ctl_s1.filter > pnguf_pkg::FLT_BAD);
		unique case (ctl_s1.filter)
			pnguf_pkg::FLT_NONE:  pred = 8'd0;
			pnguf_pkg::FLT_SUB:   pred = a;
			pnguf_pkg::FLT_UP:    pred = b;
			pnguf_pkg::FLT_AVG:   pred = sum_ab[8:1];
			pnguf_pkg::FLT_PAETH: pred = paeth(a, b, c);
			default:              pred = 8'd0;
		endcase
		r = bad ? 8'd0 : (x_s1 + pred);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
				left_hist_q[k]   <= 8'd0;
				upleft_hist_q[k] <= 8'd0;
			end
		end else if (adv && v_s1) begin
			for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
				left_hist_q[k]   <= left_hist_q[k-1];
				upleft_hist_q[k] <= upleft_hist_q[k-1];
			end
			left_hist_q[0]   <= r;
			upleft_hist_q[0] <= b;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			pixel_q   <= r;
			row_end_q <= ctl_s1.last;
			bad_q     <= bad;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_byte = pixel_q;
	assign row_end    = row_end_q;
	assign bad_filter = bad_q;

endmodule

>>> rtl/core/png_scanline_unfilter_core.sv
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// png row unfilter (none, sub, up, average, paeth), one byte per transaction
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | sink      | in_valid / in_stall  | data_byte, image_start
//  out     | source    | out_valid / out_stall| pixel_byte, row_end, bad_filter
//  cfg     | sink      | cfg_we               | cfg_index, cfg_data
//
//  sustained rate is one byte per cycle on both sides while out_stall is low; a
//  filter-type byte takes one input transaction and gives no output transaction
//  an accepted byte passes the queue, the registered line buffer read and the
//  output register on its way to out_valid
//  the left neighbor loop closes through the predictor and the left history, and a
//  line buffer write still in flight is forwarded to the next read
//  reset clears control and history state; the line buffer needs no clearing pass
//  out_stall holds the back end; the 4-entry queue absorbs it until in_stall rises
//
module png_scanline_unfilter_core #(
	parameter int MAX_ROW_BYTES   = 8192,
	parameter int MAX_PIXEL_BYTES = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [pnguf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pnguf_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input stream
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pnguf_pkg::DATA_W-1:0]      data_byte,
	input  logic                              image_start,
	// output stream
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pnguf_pkg::DATA_W-1:0]      pixel_byte,
	output logic                              row_end,
	output logic                              bad_filter
);

	localparam int CW     = $clog2(MAX_ROW_BYTES);
	localparam int PW     = $clog2(MAX_PIXEL_BYTES);
	localparam int CTL_W  = $bits(pnguf_pkg::pnguf_ctl_t);
	localparam int QW     = CTL_W + pnguf_pkg::DATA_W + CW + PW;
	localparam int Q_LOG2 = 2;

	logic                            accept;
	logic                            push;
	pnguf_pkg::pnguf_ctl_t           op_ctl;
	logic [pnguf_pkg::DATA_W-1:0]    op_data;
	logic [CW-1:0]                   op_col;
	logic [PW-1:0]                   op_idx;

	logic                            q_pop;
	logic                            q_empty;
	logic                            q_full;
	logic [QW-1:0]                   q_head;

	pnguf_pkg::pnguf_ctl_t           hd_ctl;
	logic [pnguf_pkg::DATA_W-1:0]    hd_data;
	logic [CW-1:0]                   hd_col;
	logic [PW-1:0]                   hd_idx;

	// input transaction completes whenever the queue has room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// front: row position, filter type, neighbor availability
	pnguf_front #(
		.MAX_ROW_BYTES  (MAX_ROW_BYTES),
		.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.accept     (accept),
		.data_byte  (data_byte),
		.image_start(image_start),
		.push       (push),
		.op_ctl     (op_ctl),
		.op_data    (op_data),
		.op_col     (op_col),
		.op_idx     (op_idx)
	);

	// decouples front from back so an output stall does not stop intake at once
	pnguf_queue #(
		.WIDTH     (QW),
		.DEPTH_LOG2(Q_LOG2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({op_ctl, op_data, op_col, op_idx}),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	assign {hd_ctl, hd_data, hd_col, hd_idx} = q_head;

	// back: line buffer, predictor, output register
	pnguf_back #(
		.MAX_ROW_BYTES  (MAX_ROW_BYTES),
		.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.hd_ctl    (hd_ctl),
		.hd_data   (hd_data),
		.hd_col    (hd_col),
		.hd_idx    (hd_idx),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_byte(pixel_byte),
		.row_end   (row_end),
		.bad_filter(bad_filter)
	);

endmodule

>>> rtl/core/pnguf_checker.sv
// ----------------------------------------------------------------------------
// pnguf_checker
// port-level checks of the png scanline unfilter core
// ----------------------------------------------------------------------------
module pnguf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] pixel_byte,
	input logic       row_end,
	input logic       bad_filter
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=>
			$stable(pixel_byte) && $stable(row_end) && $stable(bad_filter))
		else $error("output payload changed while stalled");

	// bytes of a row with an unknown filter type come out as zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_filter |-> pixel_byte == 8'd0)
		else $error("bad filter row gave a nonzero byte");

	// the queue only fills through an input transaction
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("in_stall rose without an input transaction");

endmodule

bind png_scanline_unfilter_core pnguf_checker u_pnguf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pixel_byte(pixel_byte),
	.row_end   (row_end),
	.bad_filter(bad_filter)
);
